// ===== rtl/sdp_pkg.sv =====
// Shared types and constants for the signed distance primitive block.
package sdp_pkg;

    // Shape selector codes (register 0)
    localparam logic [1:0] SHAPE_SPHERE = 2'd0;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd1;
    localparam logic [1:0] SHAPE_LINE   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS     = 3'd4;

    // Control carried alongside each item through the pipeline
    typedef struct packed {
        logic valid;
        logic line;
    } ctl_t;

endpackage

// ===== rtl/signed_distance_primitive_top.sv =====
// Top level of the signed distance primitive: config registers, front end, root chain.
//
// Use:
//   Configuration: write shape_kind, center_x/y/z and radius through the
//   cfg channel (cfg_index 0..4, cfg_data); a transfer completes when
//   cfg_valid and cfg_ready are both high. cfg_ready is always high.
//   Indexes 5..7 are ignored. Write only while no point is in flight.
//   Points: drive point_x/y/z with start high; busy is always low, so a
//   point is taken on every cycle that start is high.
//   Results: signed_distance is shown for one cycle with done high. The
//   receiver cannot stall; there is no back-pressure anywhere.
// Pipeline:
//   Three front-end stages (difference, square, sum of squares), one
//   chain cell per root bit (COORD_BITS + 1 cells, each doing one
//   restoring step of the integer square root), and the output register.
//   Throughput is one point per cycle; every stage advances each cycle.
// Reset:
//   rst_n clears the registers to zero (sphere of radius zero at the
//   origin) and drops every in-flight valid bit, so no stray result.
module signed_distance_primitive_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // point channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          point_x,
    input  logic signed [COORD_BITS-1:0]          point_y,
    input  logic signed [COORD_BITS-1:0]          point_z,
    // result
    output logic                                  done,
    output logic signed [COORD_BITS+1:0]          signed_distance,
    // configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sdp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_data
);

    localparam int R = COORD_BITS + 1;   // root bits, also line diff width
    localparam int S = 2 * R;            // radicand bits
    localparam int O = COORD_BITS + 2;   // output width

    // ---------------- configuration registers ----------------
    logic [1:0]                   shape_kind_reg;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic signed [COORD_BITS-1:0] center_z_reg;
    logic [COORD_BITS-2:0]        radius_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg <= sdp_pkg::SHAPE_SPHERE;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            radius_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sdp_pkg::REG_SHAPE_KIND: shape_kind_reg <= cfg_data[1:0];
                sdp_pkg::REG_CENTER_X:   center_x_reg   <= cfg_data;
                sdp_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_data;
                sdp_pkg::REG_CENTER_Z:   center_z_reg   <= cfg_data;
                sdp_pkg::REG_RADIUS:     radius_reg     <= cfg_data[COORD_BITS-2:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ---------------- front end ----------------
    sdp_pkg::ctl_t       chain_ctl  [R+1];
    logic [S-1:0]        chain_sum  [R+1];
    logic [R-1:0]        chain_root [R+1];
    logic [R+1:0]        chain_rem  [R+1];
    logic signed [R-1:0] chain_line [R+1];

    sdp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !busy),
        .shape_kind (shape_kind_reg),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .center_z   (center_z_reg),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .ctl        (chain_ctl[0]),
        .sum        (chain_sum[0]),
        .line_diff  (chain_line[0])
    );

    // root and remainder start empty
    assign chain_root[0] = '0;
    assign chain_rem[0]  = '0;

    // ---------------- square-root chain ----------------
    // cell i settles root bit R-1-i, most significant first
    for (genvar i = 0; i < R; i++)
    begin : g_cell
        sdp_sqrt_cell #(
            .ROOT_BITS (R),
            .STEP      (R - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (chain_ctl[i]),
            .sum_in   (chain_sum[i]),
            .root_in  (chain_root[i]),
            .rem_in   (chain_rem[i]),
            .line_in  (chain_line[i]),
            .ctl_out  (chain_ctl[i+1]),
            .sum_out  (chain_sum[i+1]),
            .root_out (chain_root[i+1]),
            .rem_out  (chain_rem[i+1]),
            .line_out (chain_line[i+1])
        );
    end

    // ---------------- output register ----------------
    logic              done_reg;
    logic signed [O-1:0] dist_reg;
    logic signed [O-1:0] dist_next;

    // radius minus root, or the plain x offset in line mode
    always_comb
    begin
        if (chain_ctl[R].line)
            dist_next = {chain_line[R][R-1], chain_line[R]};
        else
            dist_next = $signed({3'b000, radius_reg}) - $signed({1'b0, chain_root[R]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_ctl[R].valid;
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign done            = done_reg;
    assign signed_distance = dist_reg;

endmodule

// ===== rtl/sdp_front.sv =====
// Front end: coordinate differences, squares and the sum of squares.
module sdp_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [1:0]                      shape_kind,
    input  logic signed [COORD_BITS-1:0]    center_x,
    input  logic signed [COORD_BITS-1:0]    center_y,
    input  logic signed [COORD_BITS-1:0]    center_z,
    input  logic signed [COORD_BITS-1:0]    point_x,
    input  logic signed [COORD_BITS-1:0]    point_y,
    input  logic signed [COORD_BITS-1:0]    point_z,
    output sdp_pkg::ctl_t                   ctl,
    output logic [2*COORD_BITS+1:0]         sum,
    output logic signed [COORD_BITS:0]      line_diff
);

    localparam int D = COORD_BITS + 1;
    localparam int S = 2 * COORD_BITS + 2;

    logic signed [D-1:0] dx, dy, dz;
    logic [D-1:0]        mx, my, mz;

    // stage 1: magnitudes
    sdp_pkg::ctl_t       ctl1_reg;
    logic [D-1:0]        mx_reg, my_reg, mz_reg;
    logic signed [D-1:0] ld1_reg;
    // stage 2: squares
    sdp_pkg::ctl_t       ctl2_reg;
    logic [S-1:0]        sx_reg, sy_reg, sz_reg;
    logic signed [D-1:0] ld2_reg;
    // stage 3: sum
    sdp_pkg::ctl_t       ctl3_reg;
    logic [S-1:0]        sum_reg;
    logic signed [D-1:0] ld3_reg;

    assign dx = {point_x[COORD_BITS-1], point_x} - {center_x[COORD_BITS-1], center_x};
    assign dy = {point_y[COORD_BITS-1], point_y} - {center_y[COORD_BITS-1], center_y};
    assign dz = {point_z[COORD_BITS-1], point_z} - {center_z[COORD_BITS-1], center_z};
    assign mx = dx[D-1] ? D'(-dx) : D'(dx);
    assign my = dy[D-1] ? D'(-dy) : D'(dy);
    // z drops out in circle mode
    assign mz = (shape_kind == sdp_pkg::SHAPE_CIRCLE) ? '0 :
                (dz[D-1] ? D'(-dz) : D'(dz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg.valid <= start;
            ctl1_reg.line  <= shape_kind[1];
            ctl2_reg       <= ctl1_reg;
            ctl3_reg       <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx;
        my_reg  <= my;
        mz_reg  <= mz;
        ld1_reg <= dx;
        sx_reg  <= mx_reg * mx_reg;
        sy_reg  <= my_reg * my_reg;
        sz_reg  <= mz_reg * mz_reg;
        ld2_reg <= ld1_reg;
        sum_reg <= sx_reg + sy_reg + sz_reg;
        ld3_reg <= ld2_reg;
    end

    assign ctl       = ctl3_reg;
    assign sum       = sum_reg;
    assign line_diff = ld3_reg;

endmodule

// ===== rtl/sdp_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per item.
module sdp_sqrt_cell #(
    parameter int ROOT_BITS = 25,
    parameter int STEP      = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdp_pkg::ctl_t                 ctl_in,
    input  logic [2*ROOT_BITS-1:0]        sum_in,
    input  logic [ROOT_BITS-1:0]          root_in,
    input  logic [ROOT_BITS+1:0]          rem_in,
    input  logic signed [ROOT_BITS-1:0]   line_in,
    output sdp_pkg::ctl_t                 ctl_out,
    output logic [2*ROOT_BITS-1:0]        sum_out,
    output logic [ROOT_BITS-1:0]          root_out,
    output logic [ROOT_BITS+1:0]          rem_out,
    output logic signed [ROOT_BITS-1:0]   line_out
);

    localparam int W = ROOT_BITS + 2;

    logic [W-1:0] rem_sh;
    logic [W-1:0] trial;
    logic         ge;

    sdp_pkg::ctl_t               ctl_reg;
    logic [2*ROOT_BITS-1:0]      sum_reg;
    logic [ROOT_BITS-1:0]        root_reg;
    logic [W-1:0]                rem_reg;
    logic signed [ROOT_BITS-1:0] line_reg;

    // bring down the next pair of radicand bits
    assign rem_sh = {rem_in[W-3:0], sum_in[2*STEP+1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_in;
        line_reg <= line_in;
        root_reg <= {root_in[ROOT_BITS-2:0], ge};
        rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
    end

    assign ctl_out  = ctl_reg;
    assign sum_out  = sum_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign line_out = line_reg;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the signed distance primitive: streamed points checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W         = 24;
    localparam int DIST_W          = COORD_W + 2;
    localparam int LATENCY         = COORD_W + 5;   // register stages from point in to result out in the top level
    localparam int CYCLE_LIMIT     = 200000;        // watchdog limit for the whole run
    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_GAP         = 16;

    // Selector code the block does not name; it must behave as the line shape
    localparam logic [1:0] SHAPE_SPARE = 2'd3;
    // Indexes past the last register; writes there must change nothing
    localparam logic [sdp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [sdp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Mirror of the shape registers, the distance predictor and the queue of
    // distances still owed by the pipeline.
    class distance_checker;
        logic [1:0]         shape;
        coord_t             cx;
        coord_t             cy;
        coord_t             cz;
        logic [COORD_W-2:0] radius;
        dist_t              owed_distances[$];
        int unsigned        mismatches;

        function new();
            shape      = sdp_pkg::SHAPE_SPHERE;
            cx         = '0;
            cy         = '0;
            cz         = '0;
            radius     = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [sdp_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [COORD_W-1:0] data);
            case (idx)
                sdp_pkg::REG_SHAPE_KIND: shape  = data[1:0];
                sdp_pkg::REG_CENTER_X:   cx     = data;
                sdp_pkg::REG_CENTER_Y:   cy     = data;
                sdp_pkg::REG_CENTER_Z:   cz     = data;
                sdp_pkg::REG_RADIUS:     radius = data[COORD_W-2:0];
                default: ;
            endcase
        endfunction

        function dist_t distance_of(coord_t px, coord_t py, coord_t pz);
            longint          dx;
            longint          dy;
            longint          dz;
            longint unsigned sum;
            longint unsigned root;
            longint unsigned trial;
            // line mode, and the spare selector with it
            if (shape != sdp_pkg::SHAPE_SPHERE && shape != sdp_pkg::SHAPE_CIRCLE)
                return dist_t'(longint'(px) - longint'(cx));
            dx  = longint'(px) - longint'(cx);
            dy  = longint'(py) - longint'(cy);
            dz  = longint'(pz) - longint'(cz);
            sum = dx * dx + dy * dy;
            if (shape == sdp_pkg::SHAPE_SPHERE)
                sum += dz * dz;
            // floor of the root, built one bit at a time from the top
            root = 0;
            for (int b = COORD_W + 1; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sum)
                    root = trial;
            end
            return dist_t'(longint'(radius) - longint'(root));
        endfunction

        function void note_point(coord_t px, coord_t py, coord_t pz);
            owed_distances.push_back(distance_of(px, py, pz));
        endfunction

        function void check_distance(dist_t got);
            dist_t want;
            if (owed_distances.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] distance %0d arrived with no point outstanding", $time, got);
                return;
            end
            want = owed_distances.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] signed_distance: expected %0d, got %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return owed_distances.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // DUT connections
    // ---------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    coord_t                           point_x;
    coord_t                           point_y;
    coord_t                           point_z;
    logic                             done;
    dist_t                            signed_distance;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [sdp_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_W-1:0]               cfg_data;

    signed_distance_primitive_top #(
        .COORD_BITS(COORD_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .done           (done),
        .signed_distance(signed_distance),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    distance_checker book;
    int              idle_pct = 0;      // chance in a hundred that the sender idles a cycle
    int unsigned     cycles   = 0;

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung pipeline or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Results cannot be held off, so every cycle with done high is a transfer.
    // Values are sampled at the edge that ends the cycle, before any update.
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_distance(signed_distance);
    end

    // ---------------------------------------------------------------------
    // Driving tasks; each is entered and left on a rising edge
    // ---------------------------------------------------------------------

    // One register transfer. cfg_valid is left high so back-to-back writes
    // need no second assignment in the same step; the caller drops it.
    task automatic write_reg(input logic [sdp_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        book.set_reg(idx, data);
    endtask

    // Stops the point stream and waits for every owed distance. Every point
    // yields exactly one result, so an empty queue means an empty pipeline.
    task automatic wait_idle();
        start <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Rewrites every register, plus one write to a spare index that must be
    // ignored. Only done with nothing in flight.
    task automatic program_shape(input logic [COORD_W-1:0] shape_word,
                                 input logic [COORD_W-1:0] cx_word,
                                 input logic [COORD_W-1:0] cy_word,
                                 input logic [COORD_W-1:0] cz_word,
                                 input logic [COORD_W-1:0] radius_word);
        logic [sdp_pkg::CFG_IDX_BITS-1:0] spare;
        spare = sdp_pkg::CFG_IDX_BITS'($urandom_range(REG_SPARE_HI, REG_SPARE_LO));
        wait_idle();
        write_reg(sdp_pkg::REG_SHAPE_KIND, shape_word);
        write_reg(sdp_pkg::REG_CENTER_X, cx_word);
        write_reg(sdp_pkg::REG_CENTER_Y, cy_word);
        write_reg(sdp_pkg::REG_CENTER_Z, cz_word);
        write_reg(sdp_pkg::REG_RADIUS, radius_word);
        write_reg(spare, COORD_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // One point transfer, after a random idle gap. Junk coordinates sit on
    // the bus while start is low.
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start   <= 1'b0;
            point_x <= coord_t'($urandom);
            point_y <= coord_t'($urandom);
            point_z <= coord_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        do @(posedge clk); while (busy);
        book.note_point(px, py, pz);
    endtask

    // ---------------------------------------------------------------------
    // Random values
    // ---------------------------------------------------------------------
    function automatic coord_t extreme_coord();
        case ($urandom_range(3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return coord_t'(0);
            default: return coord_t'(-1);
        endcase
    endfunction

    function automatic coord_t random_centre();
        if ($urandom_range(4) == 0)
            return extreme_coord();
        return coord_t'($urandom);
    endfunction

    // Top bit is above the 23-bit register and must be dropped by the block.
    function automatic logic [COORD_W-1:0] random_radius_word();
        logic top;
        top = 1'($urandom);
        case ($urandom_range(3))
            0:       return {top, {(COORD_W-1){1'b0}}};
            1:       return {top, {(COORD_W-1){1'b1}}};
            2:       return {top, (COORD_W-1)'($urandom_range(4095))};
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Half the points near the centre or near the surface, where the root and
    // the sign of the result are most sensitive; one in ten at extreme corners; the rest anywhere.
    function automatic point_t make_point();
        point_t p;
        int     r;
        p.x = coord_t'($urandom);
        p.y = coord_t'($urandom);
        p.z = coord_t'($urandom);
        case ($urandom_range(9))
            4:
            begin
                p.x = extreme_coord();
                p.y = extreme_coord();
                p.z = extreme_coord();
            end
            5, 6, 7:
            begin
                p.x = coord_t'(int'(book.cx) + int'($urandom_range(512)) - 256);
                p.y = coord_t'(int'(book.cy) + int'($urandom_range(512)) - 256);
                p.z = coord_t'(int'(book.cz) + int'($urandom_range(512)) - 256);
            end
            8, 9:
            begin
                r   = $urandom_range(1) ? int'(book.radius) : -int'(book.radius);
                p.x = coord_t'(int'(book.cx) + r + int'($urandom_range(8)) - 4);
                p.y = coord_t'(int'(book.cy) + int'($urandom_range(8)) - 4);
                p.z = coord_t'(int'(book.cz) + int'($urandom_range(8)) - 4);
            end
            default: ;
        endcase
        return p;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial
    begin
        point_t     p;
        logic [1:0] shape_cycle[6];

        shape_cycle = '{sdp_pkg::SHAPE_SPHERE, sdp_pkg::SHAPE_CIRCLE, sdp_pkg::SHAPE_SPHERE,
                        sdp_pkg::SHAPE_LINE, sdp_pkg::SHAPE_CIRCLE, SHAPE_SPARE};
        book = new();

        rst_n     <= 1'b0;
        start     <= 1'b0;
        point_x   <= '0;
        point_y   <= '0;
        point_z   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, no idling ---

        // Straight out of reset: sphere of radius zero at the origin
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0));
        send_point(COORD_MIN, COORD_MAX, coord_t'(-1));

        // Sphere at the top corner with the largest radius: the opposite
        // corner gives the largest sum of squares the block can see
        program_shape({22'd0, sdp_pkg::SHAPE_SPHERE}, COORD_MAX, COORD_MAX, COORD_MAX,
                      {1'b0, {(COORD_W-1){1'b1}}});
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(coord_t'(COORD_MAX - 1), COORD_MAX, COORD_MAX);

        // Circle: z of the point and of the centre must not matter
        program_shape({22'd0, sdp_pkg::SHAPE_CIRCLE}, COORD_MIN, COORD_MIN, COORD_MAX,
                      {1'b0, {(COORD_W-1){1'b1}}});
        send_point(COORD_MAX, COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(coord_t'(COORD_MIN + 3), coord_t'(COORD_MIN + 4), coord_t'(0));

        // Vertical line at the far left: y and z are ignored
        program_shape({22'd0, sdp_pkg::SHAPE_LINE}, COORD_MIN, COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
        send_point(COORD_MAX, coord_t'($urandom), coord_t'($urandom));
        send_point(COORD_MIN, coord_t'($urandom), coord_t'($urandom));
        send_point(coord_t'(0), coord_t'($urandom), coord_t'($urandom));

        // All-ones words: spare selector (acts as a line) and a radius word
        // whose top bit lies outside the register
        program_shape({22'h3FFFFF, SHAPE_SPARE}, COORD_MAX, coord_t'(0), coord_t'(0),
                      {COORD_W{1'b1}});
        send_point(COORD_MIN, coord_t'($urandom), coord_t'($urandom));
        send_point(COORD_MAX, coord_t'($urandom), coord_t'($urandom));

        // Sphere at the origin, exact roots on both sides of zero
        program_shape({22'd0, sdp_pkg::SHAPE_SPHERE}, '0, '0, '0, {COORD_W{1'b1}});
        send_point(coord_t'(3), coord_t'(4), coord_t'(0));
        send_point(coord_t'(-3), coord_t'(0), coord_t'(-4));
        send_point(coord_t'(0), coord_t'(0), coord_t'(0));

        // --- random part: sender idles 16%, then 70%, then not at all ---
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_pct = (ph < 5) ? 16 : (ph < 10) ? 70 : 0;
            program_shape({22'($urandom), shape_cycle[ph % 6]},
                          random_centre(), random_centre(), random_centre(),
                          random_radius_word());
            repeat (ITEMS_PER_PHASE)
            begin
                p = make_point();
                send_point(p.x, p.y, p.z);
            end
        end

        // Drain, then give any stray result time to show up
        wait_idle();
        repeat (LATENCY + 8) @(posedge clk);

        if (book.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
